// File: rtl/core/midi_byte_message_parser_defines.svh
// assertion macros for the parser top level
`ifndef MIDI_BYTE_MESSAGE_PARSER_DEFINES_SVH
`define MIDI_BYTE_MESSAGE_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is low
`define MBMP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled while reset is low
`define MBMP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MBMP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define MBMP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: rtl/core/mbmp_pkg.sv
// types, status codes and event codes of the midi byte message parser
package mbmp_pkg;

    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 3;
    localparam int CHAN_W    = 4;
    localparam int DATA_W    = 7;
    localparam int BPM_W     = 9;

    // status bytes
    localparam logic [BYTE_W-1:0] ST_NOTE_ON     = 8'h90;
    localparam logic [BYTE_W-1:0] ST_CONTROLLER  = 8'hB0;
    localparam logic [BYTE_W-1:0] ST_PROG_CHANGE = 8'hC0;
    localparam logic [BYTE_W-1:0] ST_CHAN_PRESS  = 8'hD0;
    localparam logic [BYTE_W-1:0] ST_SYSEX       = 8'hF0;
    localparam logic [BYTE_W-1:0] ST_QFRAME      = 8'hF1;
    localparam logic [BYTE_W-1:0] ST_SONG_SELECT = 8'hF3;
    localparam logic [BYTE_W-1:0] RT_START       = 8'hFA;
    localparam logic [BYTE_W-1:0] RT_STOP        = 8'hFC;

    // controller number that carries the tempo
    localparam logic [DATA_W-1:0] CC_TEMPO       = 7'd2;
    localparam logic [BPM_W-1:0]  TEMPO_BASE     = 9'd120;

    // event kinds
    localparam logic [KIND_W-1:0] EV_START   = 3'd0;
    localparam logic [KIND_W-1:0] EV_STOP    = 3'd1;
    localparam logic [KIND_W-1:0] EV_NOTE    = 3'd2;
    localparam logic [KIND_W-1:0] EV_PATTERN = 3'd3;
    localparam logic [KIND_W-1:0] EV_TEMPO   = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] running_status;
        logic [CHAN_W-1:0] voice_channel;
        logic              second_pending;
        logic [DATA_W-1:0] held_first_byte;
        logic              play_flag;
    } mbmp_state_t;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [CHAN_W-1:0] msg_channel;
        logic [DATA_W-1:0] data_first;
        logic [DATA_W-1:0] data_second;
        logic [BPM_W-1:0]  tempo_bpm;
        logic              playing;
    } mbmp_event_t;

endpackage

// File: rtl/core/mbmp_decode.sv
// per-byte decode: next parser state and the optional event for one byte
module mbmp_decode import mbmp_pkg::*; (
    input  logic [BYTE_W-1:0] rx_byte,
    input  mbmp_state_t       state,
    output mbmp_state_t       state_next,
    output mbmp_event_t       event_out,
    output logic              event_valid
);

    logic [BPM_W-1:0] bpm;

    // 120 + 3*value as a shift and add
    assign bpm = TEMPO_BASE + {2'b00, rx_byte[DATA_W-1:0]}
               + {1'b0, rx_byte[DATA_W-1:0], 1'b0};

    always_comb begin
        state_next  = state;
        event_out   = '0;
        event_valid = 1'b0;

        if (rx_byte[7]) begin
            if (rx_byte[7:3] == 5'b11111) begin
                // real time: never touches running status or pending data
                if (rx_byte == RT_START && !state.play_flag) begin
                    state_next.play_flag = 1'b1;
                    event_valid          = 1'b1;
                    event_out.event_kind = EV_START;
                end else if (rx_byte == RT_STOP && state.play_flag) begin
                    state_next.play_flag = 1'b0;
                    event_valid          = 1'b1;
                    event_out.event_kind = EV_STOP;
                end
            end else begin
                if (rx_byte[7:4] == 4'hF) begin
                    state_next.running_status = rx_byte;
                end else begin
                    state_next.voice_channel  = rx_byte[3:0];
                    state_next.running_status = {rx_byte[7:4], 4'h0};
                end
                state_next.second_pending = 1'b0;
            end
        end else if (!state.second_pending) begin
            unique case (state.running_status) inside
                ST_PROG_CHANGE: begin
                    event_valid          = 1'b1;
                    event_out.event_kind = EV_PATTERN;
                    event_out.data_first = {4'b0000, rx_byte[2:0]};
                end
                ST_CHAN_PRESS, ST_SYSEX, ST_QFRAME, ST_SONG_SELECT: begin
                    // single data byte, swallowed
                end
                default: begin
                    state_next.second_pending  = 1'b1;
                    state_next.held_first_byte = rx_byte[DATA_W-1:0];
                end
            endcase
        end else begin
            state_next.second_pending = 1'b0;
            if (state.running_status == ST_NOTE_ON && state.held_first_byte != '0) begin
                state_next.play_flag  = 1'b1;
                event_valid           = 1'b1;
                event_out.event_kind  = EV_NOTE;
                event_out.data_first  = state.held_first_byte;
                event_out.data_second = rx_byte[DATA_W-1:0];
            end else if ((state.running_status == ST_NOTE_ON
                          || state.running_status == ST_CONTROLLER)
                         && state.held_first_byte == CC_TEMPO) begin
                event_valid           = 1'b1;
                event_out.event_kind  = EV_TEMPO;
                event_out.data_second = rx_byte[DATA_W-1:0];
                event_out.tempo_bpm   = bpm;
            end
        end

        event_out.msg_channel = state_next.voice_channel;
        event_out.playing     = state_next.play_flag;
    end

endmodule

// File: rtl/core/midi_byte_message_parser.sv
// midi byte message parser: top level with state and result registers
//
// s_valid/s_ready/s_rx_byte carry one received midi byte per transfer.
// m_valid/m_ready and the m_ payload ports carry one event per transfer:
// start, stop, note on, pattern select or tempo, with the current channel
// and the play flag after the byte.
// A byte is decoded in the cycle it is accepted; the parser state updates
// at that edge and an event, when the byte causes one, is valid on the
// m_ ports from the next cycle.
// Throughput is one byte per cycle while the receiver keeps up, set by the
// single output register: s_ready is high whenever that register is empty or being emptied.
// Bytes that cause no event never occupy the output register.
// When the receiver stalls with an event pending, s_ready drops until
// the event is taken; nothing is dropped.
// Synchronous active-low reset clears running status, channel, pending
// data byte, held byte and play flag, and empties the output register.
`include "midi_byte_message_parser_defines.svh"

module midi_byte_message_parser import mbmp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [KIND_W-1:0] m_event_kind,
    output logic [CHAN_W-1:0] m_msg_channel,
    output logic [DATA_W-1:0] m_data_first,
    output logic [DATA_W-1:0] m_data_second,
    output logic [BPM_W-1:0]  m_tempo_bpm,
    output logic              m_playing
);

    mbmp_state_t state_reg;
    mbmp_state_t state_next;
    mbmp_event_t event_reg;
    mbmp_event_t event_next;
    logic        event_hit;
    logic        out_valid_reg;
    logic        in_xfer;

    mbmp_decode u_decode (
        .rx_byte     (s_rx_byte),
        .state       (state_reg),
        .state_next  (state_next),
        .event_out   (event_next),
        .event_valid (event_hit)
    );

    assign s_ready = !out_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_xfer) begin
                state_reg <= state_next;
            end
            if (in_xfer && event_hit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && event_hit) begin
            event_reg <= event_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_event_kind  = event_reg.event_kind;
    assign m_msg_channel = event_reg.msg_channel;
    assign m_data_first  = event_reg.data_first;
    assign m_data_second = event_reg.data_second;
    assign m_tempo_bpm   = event_reg.tempo_bpm;
    assign m_playing     = event_reg.playing;

    `MBMP_ASSERT_NOW(a_stall_blocks_input, aclk, aresetn,
        m_valid && !m_ready, !s_ready, "input taken while result stalled")
    `MBMP_ASSERT_NEXT(a_start_emits, aclk, aresetn,
        in_xfer && s_rx_byte == RT_START && !state_reg.play_flag,
        m_valid && m_event_kind == EV_START && m_playing, "start lost")
    `MBMP_ASSERT_NOW(a_tempo_value, aclk, aresetn,
        m_valid && m_event_kind == EV_TEMPO,
        m_tempo_bpm == TEMPO_BASE + 9'(m_data_second) * 9'd3, "tempo mismatch")
    `MBMP_ASSERT_NOW(a_note_plays, aclk, aresetn,
        m_valid && m_event_kind == EV_NOTE, m_playing && m_data_first != '0,
        "note on without play")
    `MBMP_ASSERT_NEXT(a_status_clears_pending, aclk, aresetn,
        in_xfer && s_rx_byte[7] && s_rx_byte[7:3] != 5'b11111,
        !state_reg.second_pending, "status byte left data pending")

endmodule

// File: tb/sv/midi_byte_message_parser_test.sv
// self-checking testbench for the midi byte message parser: directed table, then random bytes
`timescale 1ns / 100ps

module midi_byte_message_parser_test import mbmp_pkg::*;;

    localparam logic [BYTE_W-1:0] RT_FIRST = 8'hF8;

    // how a directed row is checked
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_QUIET,
        ROW_EVENT
    } row_check_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        row_check_t        check;
        mbmp_event_t       ev;
    } directed_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [BYTE_W-1:0] s_rx_byte;
    logic              m_valid;
    logic              m_ready;
    logic [KIND_W-1:0] m_event_kind;
    logic [CHAN_W-1:0] m_msg_channel;
    logic [DATA_W-1:0] m_data_first;
    logic [DATA_W-1:0] m_data_second;
    logic [BPM_W-1:0]  m_tempo_bpm;
    logic              m_playing;

    // parser state as the predictor sees it
    logic [BYTE_W-1:0] rs_status     = '0;
    logic [CHAN_W-1:0] rs_channel    = '0;
    logic              data2_pending = 1'b0;
    logic [DATA_W-1:0] first_data    = '0;
    logic              play_on       = 1'b0;

    mbmp_event_t expected_events[$];
    int          errors     = 0;
    int          sent_items = 0;
    logic        steady     = 1'b0;

    directed_row_t directed_rows [25] = '{
        '{8'hFA, ROW_EVENT,   '{EV_START, 4'd0, 7'd0, 7'd0, 9'd0, 1'b1}},
        '{8'hFA, ROW_QUIET,   '0},
        '{8'hFC, ROW_EVENT,   '{EV_STOP, 4'd0, 7'd0, 7'd0, 9'd0, 1'b0}},
        '{8'hFC, ROW_QUIET,   '0},
        '{8'h00, ROW_PREDICT, '0},
        '{8'h7F, ROW_PREDICT, '0},
        '{8'h9F, ROW_QUIET,   '0},
        '{8'h7F, ROW_QUIET,   '0},
        '{8'hF8, ROW_QUIET,   '0},
        '{8'h7F, ROW_EVENT,   '{EV_NOTE, 4'd15, 7'd127, 7'd127, 9'd0, 1'b1}},
        '{8'h00, ROW_QUIET,   '0},
        '{8'h40, ROW_QUIET,   '0},
        '{8'hB3, ROW_QUIET,   '0},
        '{8'h02, ROW_QUIET,   '0},
        '{8'h7F, ROW_EVENT,   '{EV_TEMPO, 4'd3, 7'd0, 7'd127, 9'd501, 1'b1}},
        '{8'hC0, ROW_QUIET,   '0},
        '{8'h7F, ROW_EVENT,   '{EV_PATTERN, 4'd0, 7'd7, 7'd0, 9'd0, 1'b1}},
        '{8'h08, ROW_PREDICT, '0},
        '{8'hD1, ROW_QUIET,   '0},
        '{8'h55, ROW_QUIET,   '0},
        '{8'hF0, ROW_QUIET,   '0},
        '{8'h11, ROW_QUIET,   '0},
        '{8'hF3, ROW_QUIET,   '0},
        '{8'h33, ROW_QUIET,   '0},
        '{8'hFC, ROW_EVENT,   '{EV_STOP, 4'd1, 7'd0, 7'd0, 9'd0, 1'b0}}
    };

    midi_byte_message_parser dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_msg_channel (m_msg_channel),
        .m_data_first  (m_data_first),
        .m_data_second (m_data_second),
        .m_tempo_bpm   (m_tempo_bpm),
        .m_playing     (m_playing)
    );

    function automatic mbmp_event_t event_of(input logic [KIND_W-1:0] kind,
                                             input logic [DATA_W-1:0] d1,
                                             input logic [DATA_W-1:0] d2,
                                             input logic [BPM_W-1:0]  bpm);
        mbmp_event_t ev;
        ev.event_kind  = kind;
        ev.msg_channel = rs_channel;
        ev.data_first  = d1;
        ev.data_second = d2;
        ev.tempo_bpm   = bpm;
        ev.playing     = play_on;
        return ev;
    endfunction

    // advances the predicted parser state by one byte; returns 1 when an event is due
    function automatic logic parse_byte(input logic [BYTE_W-1:0] rx, output mbmp_event_t ev);
        ev = '0;
        if (rx[7]) begin
            if ((rx & RT_FIRST) == RT_FIRST) begin
                if (rx == RT_START && !play_on) begin
                    play_on = 1'b1;
                    ev = event_of(EV_START, '0, '0, '0);
                    return 1'b1;
                end
                if (rx == RT_STOP && play_on) begin
                    play_on = 1'b0;
                    ev = event_of(EV_STOP, '0, '0, '0);
                    return 1'b1;
                end
                return 1'b0;
            end
            if (rx[7:4] == ST_SYSEX[7:4]) begin
                rs_status = rx;
            end else begin
                rs_channel = rx[3:0];
                rs_status  = {rx[7:4], 4'h0};
            end
            data2_pending = 1'b0;
            return 1'b0;
        end
        if (!data2_pending) begin
            case (rs_status)
                ST_PROG_CHANGE: begin
                    ev = event_of(EV_PATTERN, {4'd0, rx[2:0]}, '0, '0);
                    return 1'b1;
                end
                ST_CHAN_PRESS, ST_SYSEX, ST_QFRAME, ST_SONG_SELECT: return 1'b0;
                default: begin
                    data2_pending = 1'b1;
                    first_data    = rx[6:0];
                    return 1'b0;
                end
            endcase
        end
        data2_pending = 1'b0;
        if (rs_status == ST_NOTE_ON && first_data != '0) begin
            play_on = 1'b1;
            ev = event_of(EV_NOTE, first_data, rx[6:0], '0);
            return 1'b1;
        end
        // note on with note zero falls through as a controller
        if ((rs_status == ST_NOTE_ON || rs_status == ST_CONTROLLER) && first_data == CC_TEMPO) begin
            ev = event_of(EV_TEMPO, '0, rx[6:0], TEMPO_BASE + 9'(rx[6:0]) * 9'd3);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [BYTE_W-1:0] rand_data();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'h7F;
        return 8'($urandom_range(127));
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] rx,
                             input row_check_t check = ROW_PREDICT,
                             input mbmp_event_t typed_ev = '0);
        logic        fired;
        mbmp_event_t ev;
        while (!steady && $urandom_range(99) < 33) @(negedge aclk);
        s_rx_byte = rx;
        s_valid   = 1'b1;
        do @(posedge aclk); while (!s_ready);
        fired = parse_byte(rx, ev);
        if (check == ROW_EVENT)
            expected_events.push_back(typed_ev);
        else if (check == ROW_PREDICT && fired)
            expected_events.push_back(ev);
        if ((rx & RT_FIRST) != RT_FIRST || rx == RT_START || rx == RT_STOP)
            sent_items++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // real-time bytes may land anywhere inside a message
    task automatic send_in_msg(input logic [BYTE_W-1:0] rx);
        if ($urandom_range(15) == 0) send_byte(RT_FIRST | 8'($urandom_range(7)));
        send_byte(rx);
    endtask

    task automatic send_random_message();
        int                pick;
        int                n_data;
        int                k;
        logic              with_status;
        logic [CHAN_W-1:0] chan;
        logic [BYTE_W-1:0] status;
        logic [BYTE_W-1:0] first;
        pick        = $urandom_range(99);
        chan        = 4'($urandom_range(15));
        status      = ST_NOTE_ON | {4'h0, chan};
        first       = rand_data();
        n_data      = 2;
        with_status = $urandom_range(2) != 0;
        if (pick < 30) begin
            if ($urandom_range(3) == 0) first = 8'h00;
            else if ($urandom_range(3) == 0) first = {1'b0, CC_TEMPO};
        end else if (pick < 50) begin
            status = ST_CONTROLLER | {4'h0, chan};
            if ($urandom_range(1) == 0) first = {1'b0, CC_TEMPO};
        end else if (pick < 60) begin
            status = ST_PROG_CHANGE | {4'h0, chan};
            n_data = 1;
        end else if (pick < 68) begin
            status = {1'b1, 3'($urandom_range(6)), chan};
            if (status[7:4] == ST_CHAN_PRESS[7:4] || status[7:4] == ST_PROG_CHANGE[7:4])
                n_data = 1;
        end else if (pick < 76) begin
            status      = {ST_SYSEX[7:3], 3'($urandom_range(7))};
            n_data      = $urandom_range(3);
            with_status = 1'b1;
        end else if (pick < 86) begin
            send_in_msg($urandom_range(1) ? RT_START : RT_STOP);
            return;
        end else if (pick < 94) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            return;
        end else begin
            // cut short: only the first data byte is sent, a later byte may complete or interrupt it
            n_data = 1;
        end
        if (with_status) send_in_msg(status);
        if (n_data > 0) send_in_msg(first);
        for (k = 1; k < n_data; k++) send_in_msg(rand_data());
    endtask

    task automatic wait_for_drain();
        while (expected_events.size() != 0) @(negedge aclk);
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = steady || ($urandom_range(99) >= 33);
        end
    end

    always @(posedge aclk) begin
        mbmp_event_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_events.size() == 0) begin
                errors++;
                $display("%0t: expected no event, got kind %0d", $time, m_event_kind);
            end else begin
                want = expected_events.pop_front();
                check_field("event_kind", want.event_kind, m_event_kind);
                check_field("msg_channel", want.msg_channel, m_msg_channel);
                check_field("data_first", want.data_first, m_data_first);
                check_field("data_second", want.data_second, m_data_second);
                check_field("tempo_bpm", want.tempo_bpm, m_tempo_bpm);
                check_field("playing", want.playing, m_playing);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("midi_byte_message_parser_test: done, errors");
        $finish;
    end

    initial begin
        int i;
        int wait_cycles;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_rx_byte = '0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        for (i = 0; i < 25; i++)
            send_byte(directed_rows[i].rx, directed_rows[i].check, directed_rows[i].ev);
        wait_for_drain();

        while (sent_items < 1200) begin
            steady = sent_items >= 700 && sent_items < 1000;
            send_random_message();
        end
        steady = 1'b0;
        // sender holds off until every pending event has been taken
        wait_for_drain();
        while (sent_items < 1800) send_random_message();

        for (wait_cycles = 0; expected_events.size() != 0 && wait_cycles < 1000; wait_cycles++)
            @(negedge aclk);
        repeat (5) @(negedge aclk);
        if (expected_events.size() != 0) begin
            errors++;
            $display("%0t: expected %0d more events, got none", $time, expected_events.size());
        end
        if (errors == 0) begin
            $display("midi_byte_message_parser_test: done, clean");
        end else begin
            $display("midi_byte_message_parser_test: done, errors");
        end
        $finish;
    end

endmodule
